[hw/rtl/ppts_pkg.sv]
package ppts_pkg;

  // Action codes carried by an input item.
  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_DELAY  = 2'd1,
    ACT_SCHED  = 2'd2
  } ppts_action_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NO_TASK  = 2'd2,
    STAT_NO_READY = 2'd3
  } ppts_status_e;

  // Per-task state codes held in the status table.
  typedef enum logic [1:0] {
    TS_READY   = 2'd0,
    TS_RUNNING = 2'd1,
    TS_IDLE    = 2'd2
  } ppts_tstate_e;

  // Delay conversion constants.
  localparam logic [31:0] SEC_PER_HOUR  = 32'd3600;
  localparam logic [31:0] SEC_PER_MIN   = 32'd60;
  localparam logic [31:0] MS_PER_SEC    = 32'd1000;
  // Exact x/10 for any 32-bit x: (x * 0xCCCCCCCD) >> 35.
  localparam logic [31:0] RECIP_TEN     = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT   = 35;
  localparam int unsigned TICK_W        = 29;

  // Width of the running best priority; holds the slot count up to 256.
  localparam int unsigned PRIO_CMP_W    = 9;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  priority_req;
    logic [3:0]  task_id;
    logic [9:0]  hours;
    logic [9:0]  minutes;
    logic [9:0]  seconds;
    logic [15:0] millis;
  } ppts_in_t;

  typedef struct packed {
    logic [3:0]        running_task;
    logic              switched;
    logic [31:0]       switch_total;
    logic [TICK_W-1:0] delay_ticks;
    logic [1:0]        status;
  } ppts_out_t;

endpackage

[hw/rtl/ppts_ram.sv]
module ppts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/ppts_mac.sv]
module ppts_mac (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  output logic [63:0] p_o
);

  // Shared multiply-add: one 32x32 product plus a 32-bit addend.
  assign p_o = ({32'b0, a_i} * {32'b0, b_i}) + {32'b0, c_i};

endmodule

[hw/rtl/preemptive_priority_task_scheduler.sv]
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    in_item_i  (ppts_in_t)
// out       output     out_valid_o / out_ready_i  out_item_o (ppts_out_t)
//
// One item is worked at a time; in_ready_o is high only while the sequencer is idle.
// Create goes through its table-write state and an unused action goes straight to the
// result; delay makes four passes through the shared multiply-add unit; schedule scans
// the table one slot per cycle through the registered table read port.
// The result register lets the next item be taken while a result waits for out_ready_i.
// Reset is asynchronous and active low; the task tables need no clearing after reset.
module preemptive_priority_task_scheduler
  import ppts_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ppts_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ppts_out_t out_item_o
);

  localparam int unsigned AW = $clog2(TASK_SLOTS);
  localparam int unsigned CW = $clog2(TASK_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CREATE,
    S_DLY1,
    S_DLY2,
    S_DLY3,
    S_DLY4,
    S_SCAN,
    S_DECIDE,
    S_CMP,
    S_SWAP,
    S_RESP
  } state_e;

  state_e                state_q, state_d;
  ppts_in_t              in_q, in_d;
  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         cur_q, cur_d;
  logic [31:0]           sw_cnt_q, sw_cnt_d;
  logic [31:0]           acc_q, acc_d;
  logic [TICK_W-1:0]     ticks_q, ticks_d;
  ppts_status_e          stat_q, stat_d;
  logic                  switched_q, switched_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic                  rv_q, rv_d;
  logic [AW-1:0]         ev_q, ev_d;
  logic [PRIO_CMP_W-1:0] best_q, best_d;
  logic [AW-1:0]         pick_q, pick_d;
  logic                  found_q, found_d;
  logic                  run_q, run_d;
  logic                  out_valid_q, out_valid_d;
  ppts_out_t             out_q, out_d;

  // Table ports.
  logic [AW-1:0] rd_addr;
  logic          pr_we;
  logic [7:0]    pr_rd;
  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [1:0]    st_wdata;
  logic [1:0]    st_rd;

  // Shared multiply-add operands.
  logic [31:0] mac_a, mac_b, mac_c;
  logic [63:0] mac_p;

  logic tid_valid;

  ppts_ram #(
    .WIDTH (8),
    .DEPTH (TASK_SLOTS)
  ) u_prio_ram (
    .clk_i   (clk_i),
    .we_i    (pr_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (in_q.priority_req),
    .raddr_i (rd_addr),
    .rdata_o (pr_rd)
  );

  ppts_ram #(
    .WIDTH (2),
    .DEPTH (TASK_SLOTS)
  ) u_stat_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (rd_addr),
    .rdata_o (st_rd)
  );

  ppts_mac u_mac (
    .a_i (mac_a),
    .b_i (mac_b),
    .c_i (mac_c),
    .p_o (mac_p)
  );

  assign tid_valid = 32'(in_q.task_id) < 32'(count_q);

  // Sequencer: next state, table controls and multiply-add operands.
  always_comb begin
    state_d     = state_q;
    in_d        = in_q;
    count_d     = count_q;
    cur_d       = cur_q;
    sw_cnt_d    = sw_cnt_q;
    acc_d       = acc_q;
    ticks_d     = ticks_q;
    stat_d      = stat_q;
    switched_d  = switched_q;
    idx_d       = idx_q;
    rv_d        = rv_q;
    ev_d        = ev_q;
    best_d      = best_q;
    pick_d      = pick_q;
    found_d     = found_q;
    run_d       = run_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    rd_addr  = cur_q;
    pr_we    = 1'b0;
    st_we    = 1'b0;
    st_waddr = cur_q;
    st_wdata = TS_READY;
    mac_a    = 32'd0;
    mac_b    = 32'd0;
    mac_c    = 32'd0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          in_d       = in_item_i;
          ticks_d    = '0;
          stat_d     = STAT_OK;
          switched_d = 1'b0;
          idx_d      = '0;
          rv_d       = 1'b0;
          best_d     = PRIO_CMP_W'(TASK_SLOTS);
          found_d    = 1'b0;
          run_d      = 1'b0;
          case (in_item_i.action)
            ACT_CREATE: state_d = S_CREATE;
            ACT_DELAY:  state_d = S_DLY1;
            ACT_SCHED:  state_d = S_SCAN;
            default:    state_d = S_RESP;
          endcase
        end
      end

      // Append a ready task, or report a full table.
      S_CREATE: begin
        if (count_q >= CW'(TASK_SLOTS)) begin
          stat_d = STAT_FULL;
        end else begin
          pr_we    = 1'b1;
          st_we    = 1'b1;
          st_waddr = count_q[AW-1:0];
          st_wdata = TS_READY;
          count_d  = count_q + 1'b1;
        end
        state_d = S_RESP;
      end

      // Seconds total: hours * 3600 + seconds.
      S_DLY1: begin
        mac_a   = 32'(in_q.hours);
        mac_b   = SEC_PER_HOUR;
        mac_c   = 32'(in_q.seconds);
        acc_d   = mac_p[31:0];
        state_d = S_DLY2;
      end

      // Add minutes * 60.
      S_DLY2: begin
        mac_a   = 32'(in_q.minutes);
        mac_b   = SEC_PER_MIN;
        mac_c   = acc_q;
        acc_d   = mac_p[31:0];
        state_d = S_DLY3;
      end

      // Milliseconds total.
      S_DLY3: begin
        mac_a   = acc_q;
        mac_b   = MS_PER_SEC;
        mac_c   = 32'(in_q.millis);
        acc_d   = mac_p[31:0];
        state_d = S_DLY4;
      end

      // Divide by ten through the reciprocal and mark the task idle, or report an unknown task.
      S_DLY4: begin
        mac_a   = acc_q;
        mac_b   = RECIP_TEN;
        ticks_d = mac_p[RECIP_SHIFT+TICK_W-1:RECIP_SHIFT];
        if (tid_valid) begin
          st_we    = 1'b1;
          st_waddr = AW'(in_q.task_id);
          st_wdata = TS_IDLE;
        end else begin
          stat_d = STAT_NO_TASK;
        end
        state_d = S_RESP;
      end

      // Issue one slot read per cycle and evaluate the slot read the cycle before.
      S_SCAN: begin
        rd_addr = idx_q[AW-1:0];
        ev_d    = idx_q[AW-1:0];
        if (idx_q < count_q) begin
          idx_d = idx_q + 1'b1;
          rv_d  = 1'b1;
        end else begin
          rv_d = 1'b0;
        end
        if (rv_q) begin
          if (st_rd == TS_READY) begin
            if ({1'b0, pr_rd} < best_q) begin
              best_d  = {1'b0, pr_rd};
              pick_d  = ev_q;
              found_d = 1'b1;
            end
          end else if (st_rd == TS_RUNNING) begin
            run_d = 1'b1;
          end
        end
        if (!(idx_q < count_q) && !rv_q) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        rd_addr = cur_q;
        if (!found_q) begin
          if (!run_q) begin
            stat_d = STAT_NO_READY;
          end
          state_d = S_RESP;
        end else if (run_q) begin
          state_d = S_CMP;
        end else begin
          st_we      = 1'b1;
          st_waddr   = pick_q;
          st_wdata   = TS_RUNNING;
          cur_d      = pick_q;
          sw_cnt_d   = sw_cnt_q + 32'd1;
          switched_d = 1'b1;
          state_d    = S_RESP;
        end
      end

      // Preempt only on a strictly better pick; the running task returns to ready.
      S_CMP: begin
        if (best_q < {1'b0, pr_rd}) begin
          st_we    = 1'b1;
          st_waddr = cur_q;
          st_wdata = TS_READY;
          state_d  = S_SWAP;
        end else begin
          state_d = S_RESP;
        end
      end

      S_SWAP: begin
        st_we      = 1'b1;
        st_waddr   = pick_q;
        st_wdata   = TS_RUNNING;
        cur_d      = pick_q;
        sw_cnt_d   = sw_cnt_q + 32'd1;
        switched_d = 1'b1;
        state_d    = S_RESP;
      end

      // Hand the result to the output register once it is free.
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d           = 1'b1;
          out_d.running_task    = 4'(cur_q);
          out_d.switched        = switched_q;
          out_d.switch_total    = sw_cnt_q;
          out_d.delay_ticks     = ticks_q;
          out_d.status          = stat_q;
          state_d               = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_q        <= '0;
      count_q     <= '0;
      cur_q       <= '0;
      sw_cnt_q    <= '0;
      acc_q       <= '0;
      ticks_q     <= '0;
      stat_q      <= STAT_OK;
      switched_q  <= 1'b0;
      idx_q       <= '0;
      rv_q        <= 1'b0;
      ev_q        <= '0;
      best_q      <= '0;
      pick_q      <= '0;
      found_q     <= 1'b0;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      in_q        <= in_d;
      count_q     <= count_d;
      cur_q       <= cur_d;
      sw_cnt_q    <= sw_cnt_d;
      acc_q       <= acc_d;
      ticks_q     <= ticks_d;
      stat_q      <= stat_d;
      switched_q  <= switched_d;
      idx_q       <= idx_d;
      rv_q        <= rv_d;
      ev_q        <= ev_d;
      best_q      <= best_d;
      pick_q      <= pick_d;
      found_q     <= found_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[hw/rtl/ppts_checker.sv]
module ppts_checker
  import ppts_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input ppts_in_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input ppts_out_t out_item_o
);

  // A waiting input item holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_item_i))
    else $error("input item changed while waiting");

  // A waiting result item holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  // The block works on one item at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is in progress");

  // A task switch is always a clean schedule step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.switched |-> out_item_o.status == STAT_OK)
    else $error("switch reported with an error status");

  // Only a delay item carries a tick count; checked on switch, full and no-ready results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.switched || out_item_o.status == STAT_FULL ||
                    out_item_o.status == STAT_NO_READY)
    |-> out_item_o.delay_ticks == '0)
    else $error("tick count on a non-delay item");

endmodule

bind preemptive_priority_task_scheduler ppts_checker u_ppts_checker (.*);
